[design/crf_pkg.sv]
// crf_pkg: shared widths, constants and item types for the controller report formatter.
// No dependencies; every other design file imports it.
package crf_pkg;

    // field widths
    localparam int CHAN_W  = 2;
    localparam int BTN_W   = 9;
    localparam int DPAD_W  = 4;
    localparam int AXIS_W  = 10;
    localparam int LEVEL_W = 10;
    localparam int MODE_W  = 8;
    localparam int RPT_W   = 13;
    localparam int VAL_W   = 8;

    // raw button bit positions
    localparam int BTN_A     = 0;
    localparam int BTN_B     = 1;
    localparam int BTN_X     = 2;
    localparam int BTN_Y     = 3;
    localparam int BTN_SHR   = 4;
    localparam int BTN_TL    = 5;
    localparam int BTN_TR    = 6;
    localparam int BTN_START = 7;
    localparam int BTN_SYS   = 8;

    // d-pad bit positions
    localparam int PAD_UP = 0;
    localparam int PAD_DN = 1;
    localparam int PAD_RT = 2;
    localparam int PAD_LT = 3;

    // stick: floor((55*v + 127*256) / 256), 55/256 = 0.21484375
    localparam int STICK_GAIN   = 55;
    localparam int STICK_OFFSET = 127 * 256;
    localparam int STICK_NUM_W  = 18;

    // trigger: floor(t*0.499) as (t * ceil(0.499 * 2^20)) >> 20, exact for 10-bit t
    localparam int TRIG_SHIFT  = 20;
    localparam int TRIG_RECIP  = 523240;
    localparam int TRIG_PROD_W = LEVEL_W + TRIG_SHIFT;

    localparam logic [VAL_W-1:0] VAL_MAX     = 8'd255;
    localparam logic [VAL_W-1:0] TRIG_KNEE   = 8'd245;

    // report mode codes
    localparam logic [MODE_W-1:0] MODE_TRIG_NIB  = 8'd0;
    localparam logic [MODE_W-1:0] MODE_STICK_NIB = 8'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH_NIB  = 8'd2;
    localparam logic [MODE_W-1:0] MODE_AB_ZERO   = 8'd4;

    typedef struct packed {
        logic [CHAN_W-1:0]         channel;
        logic [BTN_W-1:0]          button_bits;
        logic [DPAD_W-1:0]         dpad_bits;
        logic signed [AXIS_W-1:0]  axis_left_x;
        logic signed [AXIS_W-1:0]  axis_left_y;
        logic signed [AXIS_W-1:0]  axis_right_x;
        logic signed [AXIS_W-1:0]  axis_right_y;
        logic [LEVEL_W-1:0]        brake_level;
        logic [LEVEL_W-1:0]        throttle_level;
        logic [MODE_W-1:0]         analog_mode;
    } t_upd_item;

    typedef struct packed {
        logic [CHAN_W-1:0] out_channel;
        logic [RPT_W-1:0]  report_buttons;
        logic [VAL_W-1:0]  stick_lx;
        logic [VAL_W-1:0]  stick_ly;
        logic [VAL_W-1:0]  stick_rx;
        logic [VAL_W-1:0]  stick_ry;
        logic [VAL_W-1:0]  trig_left;
        logic [VAL_W-1:0]  trig_right;
    } t_rpt_item;

    // merged trigger: level plus the digital button as it should read
    typedef struct packed {
        logic [VAL_W-1:0] level;
        logic             btn;
    } t_trig;

endpackage

[design/crf_if.sv]
// crf_upd_if / crf_rpt_if: valid/ready channels for gamepad updates and reports.
// Depends on crf_pkg.
interface crf_upd_if;
    import crf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CHAN_W-1:0]         channel;
    logic [BTN_W-1:0]          button_bits;
    logic [DPAD_W-1:0]         dpad_bits;
    logic signed [AXIS_W-1:0]  axis_left_x;
    logic signed [AXIS_W-1:0]  axis_left_y;
    logic signed [AXIS_W-1:0]  axis_right_x;
    logic signed [AXIS_W-1:0]  axis_right_y;
    logic [LEVEL_W-1:0]        brake_level;
    logic [LEVEL_W-1:0]        throttle_level;
    logic [MODE_W-1:0]         analog_mode;

    modport source (
        output valid, channel, button_bits, dpad_bits, axis_left_x, axis_left_y,
               axis_right_x, axis_right_y, brake_level, throttle_level, analog_mode,
        input  ready
    );
    modport sink (
        input  valid, channel, button_bits, dpad_bits, axis_left_x, axis_left_y,
               axis_right_x, axis_right_y, brake_level, throttle_level, analog_mode,
        output ready
    );
endinterface

interface crf_rpt_if;
    import crf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_channel;
    logic [RPT_W-1:0]  report_buttons;
    logic [VAL_W-1:0]  stick_lx;
    logic [VAL_W-1:0]  stick_ly;
    logic [VAL_W-1:0]  stick_rx;
    logic [VAL_W-1:0]  stick_ry;
    logic [VAL_W-1:0]  trig_left;
    logic [VAL_W-1:0]  trig_right;

    modport source (
        output valid, out_channel, report_buttons, stick_lx, stick_ly, stick_rx, stick_ry,
               trig_left, trig_right,
        input  ready
    );
    modport sink (
        input  valid, out_channel, report_buttons, stick_lx, stick_ly, stick_rx, stick_ry,
               trig_left, trig_right,
        output ready
    );
endinterface

[design/controller_report_formatter_unit.sv]
// controller_report_formatter_unit: top level, input register, formatting logic, report register.
// Depends on crf_pkg, crf_if, crf_stick_scale, crf_trig_scale, crf_report_build.

// One gamepad update in, one controller poll report out, no kept state.
// Each update is captured in an input register; stick scaling (55/256 with
// a 127 center, Y negated), trigger scaling (x0.499, saturated, merged with
// the digital trigger button), button remap and report-mode selection all
// happen in one short combinational step into the report register. The
// block takes one update every cycle while the sink takes reports: both
// stages advance whenever the stage ahead is empty or being drained, so a
// report waiting on the sink stops updates only once the input register
// is full as well. The trigger multiply (10 x 20 bits) is the longest path
// in the formatting step; it bounds the clock rate, not the item rate.
// Reset only clears the two valid flags.
module controller_report_formatter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crf_upd_if.sink    i_upd,
    crf_rpt_if.source  o_rpt
);
    import crf_pkg::*;

    // stage 1: captured update
    logic       r_s1_valid;
    t_upd_item  r_s1_item;
    // stage 2: finished report
    logic       r_s2_valid;
    t_rpt_item  r_s2_item;

    logic       w_s1_ready;
    logic       w_s2_ready;
    t_upd_item  w_upd;
    t_rpt_item  n_s2_item;

    logic signed [AXIS_W:0] w_lx;
    logic signed [AXIS_W:0] w_ly;
    logic signed [AXIS_W:0] w_rx;
    logic signed [AXIS_W:0] w_ry;
    logic [VAL_W-1:0]       w_lx_val;
    logic [VAL_W-1:0]       w_ly_val;
    logic [VAL_W-1:0]       w_rx_val;
    logic [VAL_W-1:0]       w_ry_val;
    t_trig                  w_tl;
    t_trig                  w_tr;

    // a stage takes new data when it is empty or its item leaves this cycle
    assign w_s2_ready  = !r_s2_valid || o_rpt.ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;
    assign i_upd.ready = w_s1_ready;

    assign w_upd.channel        = i_upd.channel;
    assign w_upd.button_bits    = i_upd.button_bits;
    assign w_upd.dpad_bits      = i_upd.dpad_bits;
    assign w_upd.axis_left_x    = i_upd.axis_left_x;
    assign w_upd.axis_left_y    = i_upd.axis_left_y;
    assign w_upd.axis_right_x   = i_upd.axis_right_x;
    assign w_upd.axis_right_y   = i_upd.axis_right_y;
    assign w_upd.brake_level    = i_upd.brake_level;
    assign w_upd.throttle_level = i_upd.throttle_level;
    assign w_upd.analog_mode    = i_upd.analog_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_upd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_upd.valid) begin
            r_s1_item <= w_upd;
        end
    end

    // Y axes are negated; 11 bits hold +512 from a -512 input
    assign w_lx = (AXIS_W+1)'(r_s1_item.axis_left_x);
    assign w_ly = -((AXIS_W+1)'(r_s1_item.axis_left_y));
    assign w_rx = (AXIS_W+1)'(r_s1_item.axis_right_x);
    assign w_ry = -((AXIS_W+1)'(r_s1_item.axis_right_y));

    crf_stick_scale u_lx (.i_axis(w_lx), .o_value(w_lx_val));
    crf_stick_scale u_ly (.i_axis(w_ly), .o_value(w_ly_val));
    crf_stick_scale u_rx (.i_axis(w_rx), .o_value(w_rx_val));
    crf_stick_scale u_ry (.i_axis(w_ry), .o_value(w_ry_val));

    crf_trig_scale u_tl (
        .i_level (r_s1_item.brake_level),
        .i_btn   (r_s1_item.button_bits[BTN_TL]),
        .o_trig  (w_tl)
    );
    crf_trig_scale u_tr (
        .i_level (r_s1_item.throttle_level),
        .i_btn   (r_s1_item.button_bits[BTN_TR]),
        .o_trig  (w_tr)
    );

    crf_report_build u_build (
        .i_channel (r_s1_item.channel),
        .i_buttons (r_s1_item.button_bits),
        .i_dpad    (r_s1_item.dpad_bits),
        .i_mode    (r_s1_item.analog_mode),
        .i_lx      (w_lx_val),
        .i_ly      (w_ly_val),
        .i_rx      (w_rx_val),
        .i_ry      (w_ry_val),
        .i_tl      (w_tl),
        .i_tr      (w_tr),
        .o_rpt     (n_s2_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_s2_item <= n_s2_item;
        end
    end

    assign o_rpt.valid          = r_s2_valid;
    assign o_rpt.out_channel    = r_s2_item.out_channel;
    assign o_rpt.report_buttons = r_s2_item.report_buttons;
    assign o_rpt.stick_lx       = r_s2_item.stick_lx;
    assign o_rpt.stick_ly       = r_s2_item.stick_ly;
    assign o_rpt.stick_rx       = r_s2_item.stick_rx;
    assign o_rpt.stick_ry       = r_s2_item.stick_ry;
    assign o_rpt.trig_left      = r_s2_item.trig_left;
    assign o_rpt.trig_right     = r_s2_item.trig_right;

endmodule

[design/crf_stick_scale.sv]
// crf_stick_scale: one stick axis to its 8-bit report value.
// Depends on crf_pkg.
module crf_stick_scale (
    input  logic signed [crf_pkg::AXIS_W:0] i_axis,   // already negated for Y
    output logic [crf_pkg::VAL_W-1:0]       o_value
);
    import crf_pkg::*;

    logic signed [STICK_NUM_W-1:0] w_num;

    assign w_num = STICK_NUM_W'(i_axis) * STICK_NUM_W'(signed'(STICK_GAIN))
                 + STICK_NUM_W'(signed'(STICK_OFFSET));

    always_comb begin
        if (w_num[STICK_NUM_W-1]) begin
            o_value = '0;
        end else if (|w_num[STICK_NUM_W-2:VAL_W+8]) begin
            o_value = VAL_MAX;
        end else begin
            o_value = w_num[VAL_W+7:8];
        end
    end

endmodule

[design/crf_trig_scale.sv]
// crf_trig_scale: analog trigger scaling by 0.499, saturation and digital-button merge.
// Depends on crf_pkg.
module crf_trig_scale (
    input  logic [crf_pkg::LEVEL_W-1:0] i_level,
    input  logic                        i_btn,
    output crf_pkg::t_trig              o_trig
);
    import crf_pkg::*;

    logic [TRIG_PROD_W-1:0] w_prod;
    logic [LEVEL_W-1:0]     w_scaled;
    logic [VAL_W-1:0]       w_sat;

    assign w_prod   = TRIG_PROD_W'(i_level) * TRIG_PROD_W'(TRIG_RECIP);
    assign w_scaled = w_prod[TRIG_PROD_W-1:TRIG_SHIFT];
    assign w_sat    = (w_scaled > LEVEL_W'(VAL_MAX)) ? VAL_MAX : w_scaled[VAL_W-1:0];

    always_comb begin
        if (w_sat > TRIG_KNEE) begin
            // near full travel: button reads pressed, full level if physically pressed
            o_trig.level = i_btn ? VAL_MAX : w_sat;
            o_trig.btn   = 1'b1;
        end else if (w_sat != '0) begin
            o_trig.level = w_sat;
            o_trig.btn   = 1'b0;
        end else begin
            // no analog travel: digital button alone drives the level
            o_trig.level = i_btn ? VAL_MAX : '0;
            o_trig.btn   = i_btn;
        end
    end

endmodule

[design/crf_report_build.sv]
// crf_report_build: button remap and mode-dependent nibble/zero selection.
// Depends on crf_pkg.
module crf_report_build (
    input  logic [crf_pkg::CHAN_W-1:0] i_channel,
    input  logic [crf_pkg::BTN_W-1:0]  i_buttons,
    input  logic [crf_pkg::DPAD_W-1:0] i_dpad,
    input  logic [crf_pkg::MODE_W-1:0] i_mode,
    input  logic [crf_pkg::VAL_W-1:0]  i_lx,
    input  logic [crf_pkg::VAL_W-1:0]  i_ly,
    input  logic [crf_pkg::VAL_W-1:0]  i_rx,
    input  logic [crf_pkg::VAL_W-1:0]  i_ry,
    input  crf_pkg::t_trig             i_tl,
    input  crf_pkg::t_trig             i_tr,
    output crf_pkg::t_rpt_item         o_rpt
);
    import crf_pkg::*;

    always_comb begin
        o_rpt.out_channel    = i_channel;
        o_rpt.report_buttons = {1'b1,
                                i_dpad[PAD_RT], i_dpad[PAD_LT],
                                i_dpad[PAD_DN], i_dpad[PAD_UP],
                                i_tr.btn, i_tl.btn, i_buttons[BTN_SHR],
                                i_buttons[BTN_START] | i_buttons[BTN_SYS],
                                i_buttons[BTN_Y], i_buttons[BTN_X],
                                i_buttons[BTN_B], i_buttons[BTN_A]};
        o_rpt.stick_lx   = i_lx;
        o_rpt.stick_ly   = i_ly;
        o_rpt.stick_rx   = i_rx;
        o_rpt.stick_ry   = i_ry;
        o_rpt.trig_left  = i_tl.level;
        o_rpt.trig_right = i_tr.level;
        case (i_mode)
            MODE_TRIG_NIB: begin
                o_rpt.trig_left  = i_tl.level >> 4;
                o_rpt.trig_right = i_tr.level >> 4;
            end
            MODE_STICK_NIB: begin
                o_rpt.stick_rx = i_rx >> 4;
                o_rpt.stick_ry = i_ry >> 4;
            end
            MODE_BOTH_NIB: begin
                o_rpt.trig_left  = i_tl.level >> 4;
                o_rpt.trig_right = i_tr.level >> 4;
                o_rpt.stick_rx   = i_rx >> 4;
                o_rpt.stick_ry   = i_ry >> 4;
            end
            MODE_AB_ZERO: begin
                o_rpt.trig_left  = '0;
                o_rpt.trig_right = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

[design/crf_checker.sv]
// crf_checker: port-level assertions for controller_report_formatter_unit, plus its bind.
// Depends on crf_pkg and crf_if.
module crf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_upd_valid,
    input logic                        i_upd_ready,
    input logic                        i_rpt_valid,
    input logic                        i_rpt_ready,
    input logic [crf_pkg::RPT_W-1:0]   i_report_buttons,
    input logic [crf_pkg::VAL_W-1:0]   i_stick_lx,
    input logic [crf_pkg::VAL_W-1:0]   i_stick_ly
);
    import crf_pkg::*;

    // a held report keeps its contents
    a_rpt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rpt_valid && !i_rpt_ready |=> i_rpt_valid && $stable(i_report_buttons)
                                        && $stable(i_stick_lx))
        else $error("report changed while stalled");

    // no report right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rpt_valid)
        else $error("report valid after reset");

    // an update taken while no report is out shows as a report once it has passed the input and report registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd_valid && i_upd_ready && !i_rpt_valid |=> ##1 i_rpt_valid)
        else $error("report missing after update");

    // constant marker bit and reachable stick range 17..237
    a_rpt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rpt_valid |-> i_report_buttons[RPT_W-1]
                        && i_stick_lx >= 8'd17 && i_stick_lx <= 8'd237
                        && i_stick_ly >= 8'd17 && i_stick_ly <= 8'd237)
        else $error("report field out of range");

endmodule

bind controller_report_formatter_unit crf_checker u_crf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_upd_valid      (i_upd.valid),
    .i_upd_ready      (i_upd.ready),
    .i_rpt_valid      (o_rpt.valid),
    .i_rpt_ready      (o_rpt.ready),
    .i_report_buttons (o_rpt.report_buttons),
    .i_stick_lx       (o_rpt.stick_lx),
    .i_stick_ly       (o_rpt.stick_ly)
);

[test/tb_controller_report_formatter_unit.sv]
// tb_controller_report_formatter_unit: self-checking testbench for the controller report formatter.
// Depends on crf_pkg, crf_if (crf_upd_if, crf_rpt_if) and controller_report_formatter_unit.
// Directed updates, then random updates under three handshake idling profiles.
module tb_controller_report_formatter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import crf_pkg::*;

    // report modes that leave every value untouched (no package names for these)
    localparam logic [MODE_W-1:0] MODE_PASS    = 8'd3;
    localparam logic [MODE_W-1:0] MODE_PASS_LO = 8'd5;
    localparam logic [MODE_W-1:0] MODE_PASS_HI = 8'd255;

    // idle cycles in a row before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // settle time at the end before the last check for missing reports
    localparam int SETTLE_CYCLES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crf_upd_if upd_bus ();
    crf_rpt_if rpt_bus ();

    controller_report_formatter_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd_bus),
        .o_rpt   (rpt_bus)
    );

    always #5 i_clk = ~i_clk;

    // expected reports, oldest first
    t_rpt_item pending_reports[$];

    int send_idle_pct = 0;   // chance per cycle that the sender holds off
    int recv_idle_pct = 0;   // chance per cycle that the sink drops ready
    int updates_sent = 0;
    int directed_sent = 0;
    int reports_seen = 0;
    int mismatches = 0;
    int hang_count = 0;

    // ------------------------------------------------------------------
    // Predictor: what the formatter should report for one update
    // ------------------------------------------------------------------

    // 55/256 gain around a 127 center, clamped to 8 bits
    function automatic logic [VAL_W-1:0] scale_stick(input int v);
        int num;
        num = 55 * v + 32512;
        if (num < 0)
            return '0;
        num = num / 256;
        return (num > 255) ? 8'd255 : num[VAL_W-1:0];
    endfunction

    // level * 0.499, floored, saturated to 8 bits
    function automatic logic [VAL_W-1:0] scale_trigger(input logic [LEVEL_W-1:0] raw);
        int unsigned lvl;
        lvl = (raw * 499) / 1000;
        return (lvl > 255) ? 8'd255 : lvl[VAL_W-1:0];
    endfunction

    // digital/analog trigger merge: deep press forces the button on,
    // partial press reads released, untouched trigger follows the button
    function automatic t_trig merge_trigger(input logic [VAL_W-1:0] lvl, input logic pressed);
        t_trig t;
        if (lvl > 8'd245) begin
            t.level = pressed ? 8'd255 : lvl;
            t.btn   = 1'b1;
        end else if (lvl != 0) begin
            t.level = lvl;
            t.btn   = 1'b0;
        end else begin
            t.level = pressed ? 8'd255 : 8'd0;
            t.btn   = pressed;
        end
        return t;
    endfunction

    function automatic t_rpt_item format_report(input t_upd_item u);
        t_rpt_item r;
        t_trig tl;
        t_trig tr;
        logic [BTN_W-1:0] b;
        logic [DPAD_W-1:0] d;
        int lx;
        int ly;
        int rx;
        int ry;
        b  = u.button_bits;
        d  = u.dpad_bits;
        lx = $signed(u.axis_left_x);
        ly = $signed(u.axis_left_y);
        rx = $signed(u.axis_right_x);
        ry = $signed(u.axis_right_y);
        tl = merge_trigger(scale_trigger(u.brake_level), b[BTN_TL]);
        tr = merge_trigger(scale_trigger(u.throttle_level), b[BTN_TR]);

        r.out_channel    = u.channel;
        // bit 12 down to bit 0: 1, right, left, down, up, r, l, z, start, y, x, b, a
        r.report_buttons = {1'b1, d[PAD_RT], d[PAD_LT], d[PAD_DN], d[PAD_UP],
                            tr.btn, tl.btn, b[BTN_SHR], b[BTN_START] | b[BTN_SYS],
                            b[BTN_Y], b[BTN_X], b[BTN_B], b[BTN_A]};
        // Y axes are inverted before scaling
        r.stick_lx   = scale_stick(lx);
        r.stick_ly   = scale_stick(-ly);
        r.stick_rx   = scale_stick(rx);
        r.stick_ry   = scale_stick(-ry);
        r.trig_left  = tl.level;
        r.trig_right = tr.level;

        if (u.analog_mode == MODE_TRIG_NIB || u.analog_mode == MODE_BOTH_NIB) begin
            r.trig_left  = r.trig_left >> 4;
            r.trig_right = r.trig_right >> 4;
        end
        if (u.analog_mode == MODE_STICK_NIB || u.analog_mode == MODE_BOTH_NIB) begin
            r.stick_rx = r.stick_rx >> 4;
            r.stick_ry = r.stick_ry >> 4;
        end
        // analog A/B (always zero) take the trigger slots
        if (u.analog_mode == MODE_AB_ZERO) begin
            r.trig_left  = '0;
            r.trig_right = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Update side: driver
    // ------------------------------------------------------------------

    // valid stays high between back-to-back updates; it only drops while
    // the sender idles or pauses, and each drop is followed by a clock
    task automatic send_update(input t_upd_item u);
        while ($urandom_range(99) < send_idle_pct) begin
            upd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        upd_bus.valid          <= 1'b1;
        upd_bus.channel        <= u.channel;
        upd_bus.button_bits    <= u.button_bits;
        upd_bus.dpad_bits      <= u.dpad_bits;
        upd_bus.axis_left_x    <= u.axis_left_x;
        upd_bus.axis_left_y    <= u.axis_left_y;
        upd_bus.axis_right_x   <= u.axis_right_x;
        upd_bus.axis_right_y   <= u.axis_right_y;
        upd_bus.brake_level    <= u.brake_level;
        upd_bus.throttle_level <= u.throttle_level;
        upd_bus.analog_mode    <= u.analog_mode;
        @(posedge i_clk);
        while (!upd_bus.ready)
            @(posedge i_clk);
        pending_reports.push_back(format_report(u));
        updates_sent++;
    endtask

    // hold the sender off until every outstanding report has come back
    task automatic drain_reports();
        upd_bus.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_reports.size() != 0);
    endtask

    // centered sticks, triggers released, no buttons, plain mode
    function automatic t_upd_item neutral_update();
        t_upd_item u;
        u = '0;
        u.analog_mode = MODE_PASS;
        return u;
    endfunction

    function automatic logic signed [AXIS_W-1:0] random_axis();
        case ($urandom_range(7))
            0: return -10'sd512;
            1: return 10'sd511;
            2: return AXIS_W'($urandom_range(8) - 4);   // around center
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    // leans on the merge thresholds: 0, tiny levels that scale to 0 or 1,
    // the 245/246 knee, and full scale
    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(7))
            0: return '0;
            1: return LEVEL_W'($urandom_range(4));
            2: return LEVEL_W'($urandom_range(498, 488));
            3: return 10'd1023;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    function automatic t_upd_item random_update();
        t_upd_item u;
        u.channel        = CHAN_W'($urandom_range(3));
        u.button_bits    = BTN_W'($urandom_range(511));
        u.dpad_bits      = DPAD_W'($urandom_range(15));
        u.axis_left_x    = random_axis();
        u.axis_left_y    = random_axis();
        u.axis_right_x   = random_axis();
        u.axis_right_y   = random_axis();
        u.brake_level    = random_level();
        u.throttle_level = random_level();
        // mostly the special modes 0..5, the rest anywhere in 0..255
        u.analog_mode    = ($urandom_range(9) < 7) ? MODE_W'($urandom_range(5))
                                                   : MODE_W'($urandom_range(255));
        return u;
    endfunction

    // ------------------------------------------------------------------
    // Report side: sink stalls, checker, hang watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk)
        rpt_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] report %0d: %s expected 0x%0h, got 0x%0h",
                         $realtime, reports_seen, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_rpt_item want;
        if (i_rst_n && rpt_bus.valid && rpt_bus.ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] report %0d arrived with none outstanding",
                             $realtime, reports_seen);
            end else begin
                want = pending_reports.pop_front();
                check_field("out_channel",    16'(want.out_channel),
                            16'(rpt_bus.out_channel));
                check_field("report_buttons", 16'(want.report_buttons),
                            16'(rpt_bus.report_buttons));
                check_field("stick_lx",       16'(want.stick_lx),   16'(rpt_bus.stick_lx));
                check_field("stick_ly",       16'(want.stick_ly),   16'(rpt_bus.stick_ly));
                check_field("stick_rx",       16'(want.stick_rx),   16'(rpt_bus.stick_rx));
                check_field("stick_ry",       16'(want.stick_ry),   16'(rpt_bus.stick_ry));
                check_field("trig_left",      16'(want.trig_left),  16'(rpt_bus.trig_left));
                check_field("trig_right",     16'(want.trig_right), 16'(rpt_bus.trig_right));
            end
        end
    end

    // any handshake on either side counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (upd_bus.valid && upd_bus.ready) || (rpt_bus.valid && rpt_bus.ready))
            hang_count <= 0;
        else if (hang_count >= HANG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else
            hang_count <= hang_count + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // full-scale and near-center stick values on all four axes; the Y
    // inversion of -512 gives +512, which scales to 237
    task automatic test_stick_extremes();
        int pts[5] = '{-512, 511, 0, -1, 1};
        t_upd_item u;
        for (int i = 0; i < 5; i++) begin
            u = neutral_update();
            u.axis_left_x  = AXIS_W'(pts[i]);
            u.axis_left_y  = AXIS_W'(pts[(i + 1) % 5]);
            u.axis_right_x = AXIS_W'(pts[(i + 2) % 5]);
            u.axis_right_y = AXIS_W'(pts[(i + 3) % 5]);
            send_update(u);
        end
    endtask

    // every merge region on both sides: brake with its button held,
    // throttle at the same level with its button released
    task automatic test_trigger_merge();
        int lvl[6] = '{0, 2, 3, 492, 493, 1023};   // scaled: 0, 0, 1, 245, 246, 255
        t_upd_item u;
        for (int i = 0; i < 6; i++) begin
            u = neutral_update();
            u.brake_level          = LEVEL_W'(lvl[i]);
            u.throttle_level       = LEVEL_W'(lvl[i]);
            u.button_bits[BTN_TL]  = 1'b1;
            u.button_bits[BTN_TR]  = 1'b0;
            send_update(u);
        end
    endtask

    // each report mode with values that show both the nibble cut and zeroing
    task automatic test_report_modes();
        logic [MODE_W-1:0] modes[7] = '{MODE_TRIG_NIB, MODE_STICK_NIB, MODE_BOTH_NIB, MODE_PASS,
                                        MODE_AB_ZERO, MODE_PASS_LO, MODE_PASS_HI};
        t_upd_item u;
        for (int i = 0; i < 7; i++) begin
            u = neutral_update();
            u.axis_left_x    = 10'sd300;
            u.axis_left_y    = -10'sd150;
            u.axis_right_x   = -10'sd200;
            u.axis_right_y   = 10'sd450;
            u.brake_level    = 10'd700;
            u.throttle_level = 10'd1023;
            u.button_bits    = 9'h060;   // both trigger buttons held
            u.analog_mode    = modes[i];
            send_update(u);
        end
    endtask

    // alternating and full button/d-pad patterns across all channels;
    // start and system alone each have to light the start bit
    task automatic test_button_map();
        logic [BTN_W-1:0]  btn[4]  = '{9'h155, 9'h0AA, 9'h1FF, 9'h000};
        logic [DPAD_W-1:0] dpad[4] = '{4'h5, 4'hA, 4'hF, 4'h0};
        t_upd_item u;
        for (int i = 0; i < 4; i++) begin
            u = neutral_update();
            u.channel     = CHAN_W'(i);
            u.button_bits = btn[i];
            u.dpad_bits   = dpad[i];
            send_update(u);
        end
    endtask

    task automatic test_random_updates(input int count, input int src_pct, input int sink_pct);
        send_idle_pct = src_pct;
        recv_idle_pct = sink_pct;
        repeat (count)
            send_update(random_update());
        drain_reports();
    endtask

    initial begin
        // every block input known from time zero
        i_rst_n                = 1'b0;
        rpt_bus.ready          = 1'b0;
        upd_bus.valid          = 1'b0;
        upd_bus.channel        = '0;
        upd_bus.button_bits    = '0;
        upd_bus.dpad_bits      = '0;
        upd_bus.axis_left_x    = '0;
        upd_bus.axis_left_y    = '0;
        upd_bus.axis_right_x   = '0;
        upd_bus.axis_right_y   = '0;
        upd_bus.brake_level    = '0;
        upd_bus.throttle_level = '0;
        upd_bus.analog_mode    = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part runs under the first idling profile
        send_idle_pct = 6;
        recv_idle_pct = 75;
        test_stick_extremes();
        test_trigger_merge();
        test_report_modes();
        test_button_map();
        directed_sent = updates_sent;
        drain_reports();

        // sender mostly busy / sink mostly stalled, then swapped, then
        // full rate both ways; each phase ends with the sender paused
        test_random_updates(185, 6, 75);
        test_random_updates(185, 75, 6);
        test_random_updates(180, 0, 0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            mismatches += pending_reports.size();
            $display("%0d reports never arrived", pending_reports.size());
        end

        $display("Ran %0d updates (%0d directed, rest random over three idling profiles)",
                 updates_sent, directed_sent);
        $display("Checked %0d reports, %0d field mismatches", reports_seen, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
